### rtl/smbr_pkg.sv
// Shared types and constants for the bounded SplitMix64 random core.
`timescale 1ns / 1ps

package smbr_pkg;

    localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
    localparam int          MIX_SHIFT_A  = 30;
    localparam int          MIX_SHIFT_B  = 27;
    localparam int          MIX_SHIFT_C  = 31;
    localparam logic [63:0] SEED_RESET   = 64'd1;

    typedef enum logic {
        DIV_NEG_BOUND = 1'b0,
        DIV_DRAW      = 1'b1
    } div_sel_t;

    typedef enum logic {
        MUL_A = 1'b0,
        MUL_B = 1'b1
    } mul_sel_t;

    typedef enum logic [12:0] {
        ST_IDLE      = 13'b0000000000001,
        ST_CLASSIFY  = 13'b0000000000010,
        ST_THRESH    = 13'b0000000000100,
        ST_MIX_ADD   = 13'b0000000001000,
        ST_MULA      = 13'b0000000010000,
        ST_MULA_WAIT = 13'b0000000100000,
        ST_XOR27     = 13'b0000001000000,
        ST_MULB      = 13'b0000010000000,
        ST_MULB_WAIT = 13'b0000100000000,
        ST_XOR31     = 13'b0001000000000,
        ST_TEST      = 13'b0010000000000,
        ST_REM_WAIT  = 13'b0100000000000,
        ST_FINISH    = 13'b1000000000000
    } state_t;

    typedef struct packed {
        logic     load_bound;
        logic     div_start;
        div_sel_t div_sel;
        logic     thr_load;
        logic     gen_add;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     xor27;
        logic     xor31;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic bound_small;
        logic div_busy;
        logic mul_busy;
        logic draw_ok;
    } dp_status_t;

endpackage

### rtl/smbr_datapath.sv
// Datapath: generator state, mixer with shared 32x32 multiplier, serial divider.
`timescale 1ns / 1ps

module smbr_datapath
    import smbr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    input  logic [63:0] bound_in,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output logic [63:0] value_out
);

    logic [63:0] gen_reg, gen_next;
    logic [63:0] bound_reg, bound_next;
    logic [63:0] thr_reg, thr_next;
    logic [63:0] z_reg, z_next;
    logic [63:0] out_reg, out_next;

    // Multiplier sequencer.
    logic [63:0] mul_k_reg, mul_k_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  mul_cnt_reg, mul_cnt_next;
    logic        mul_busy_reg, mul_busy_next;
    logic [31:0] mul_op_a, mul_op_b;

    // Restoring divider, remainder only.
    logic [63:0] q_reg, q_next;
    logic [63:0] rem_reg, rem_next;
    logic [5:0]  div_cnt_reg, div_cnt_next;
    logic        div_busy_reg, div_busy_next;
    logic [64:0] div_trial;
    logic [64:0] div_diff;

    assign div_trial = {rem_reg, q_reg[63]};
    assign div_diff  = div_trial - {1'b0, bound_reg};

    always_comb begin
        case (mul_cnt_reg)
            2'd0: begin
                mul_op_a = z_reg[31:0];
                mul_op_b = mul_k_reg[31:0];
            end
            2'd1: begin
                mul_op_a = z_reg[31:0];
                mul_op_b = mul_k_reg[63:32];
            end
            default: begin
                mul_op_a = z_reg[63:32];
                mul_op_b = mul_k_reg[31:0];
            end
        endcase
    end

    always_comb begin
        gen_next      = gen_reg;
        bound_next    = bound_reg;
        thr_next      = thr_reg;
        z_next        = z_reg;
        out_next      = out_reg;
        mul_k_next    = mul_k_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        mul_cnt_next  = mul_cnt_reg;
        mul_busy_next = mul_busy_reg;
        q_next        = q_reg;
        rem_next      = rem_reg;
        div_cnt_next  = div_cnt_reg;
        div_busy_next = div_busy_reg;

        if (cfg_wr_en) begin
            gen_next = cfg_wr_data;
        end else if (cmd.gen_add) begin
            gen_next = gen_reg + GOLDEN_GAMMA;
        end

        if (cmd.load_bound) begin
            bound_next = bound_in;
        end
        if (cmd.thr_load) begin
            thr_next = rem_reg;
        end

        if (cmd.gen_add) begin
            z_next = (gen_reg + GOLDEN_GAMMA) ^ ((gen_reg + GOLDEN_GAMMA) >> MIX_SHIFT_A);
        end else if (cmd.xor27) begin
            z_next = z_reg ^ (z_reg >> MIX_SHIFT_B);
        end else if (cmd.xor31) begin
            z_next = z_reg ^ (z_reg >> MIX_SHIFT_C);
        end

        // Low 64 bits of z * k from three partial products; the high-high term
        // falls entirely above bit 63.
        if (cmd.mul_start) begin
            mul_k_next    = (cmd.mul_sel == MUL_B) ? MIX_MUL_B : MIX_MUL_A;
            mul_cnt_next  = 2'd0;
            mul_busy_next = 1'b1;
        end else if (mul_busy_reg) begin
            prod_next    = 64'(mul_op_a * mul_op_b);
            mul_cnt_next = mul_cnt_reg + 2'd1;
            case (mul_cnt_reg)
                2'd0: ;
                2'd1: acc_next = prod_reg;
                2'd2: acc_next = acc_reg + {prod_reg[31:0], 32'd0};
                default: begin
                    z_next        = acc_reg + {prod_reg[31:0], 32'd0};
                    mul_busy_next = 1'b0;
                end
            endcase
        end

        if (cmd.div_start) begin
            q_next        = (cmd.div_sel == DIV_DRAW) ? z_reg : (64'd0 - bound_reg);
            rem_next      = 64'd0;
            div_cnt_next  = 6'd0;
            div_busy_next = 1'b1;
        end else if (div_busy_reg) begin
            q_next       = {q_reg[62:0], 1'b0};
            rem_next     = div_diff[64] ? div_trial[63:0] : div_diff[63:0];
            div_cnt_next = div_cnt_reg + 6'd1;
            if (div_cnt_reg == 6'd63) begin
                div_busy_next = 1'b0;
            end
        end

        if (cmd.out_load) begin
            out_next = (bound_reg <= 64'd1) ? 64'd0 : rem_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg      <= SEED_RESET;
            mul_busy_reg <= 1'b0;
            mul_cnt_reg  <= 2'd0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= 6'd0;
        end else begin
            gen_reg      <= gen_next;
            mul_busy_reg <= mul_busy_next;
            mul_cnt_reg  <= mul_cnt_next;
            div_busy_reg <= div_busy_next;
            div_cnt_reg  <= div_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        bound_reg <= bound_next;
        thr_reg   <= thr_next;
        z_reg     <= z_next;
        out_reg   <= out_next;
        mul_k_reg <= mul_k_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        q_reg     <= q_next;
        rem_reg   <= rem_next;
    end

    assign status.bound_small = (bound_reg <= 64'd1);
    assign status.div_busy    = div_busy_reg;
    assign status.mul_busy    = mul_busy_reg;
    assign status.draw_ok     = (z_reg >= thr_reg);
    assign value_out          = out_reg;

endmodule

### rtl/smbr_ctrl.sv
// Controller: request sequencing, rejection loop and output handshake.
`timescale 1ns / 1ps

module smbr_ctrl
    import smbr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_bound = 1'b1;
                    state_next     = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                if (status.bound_small) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_NEG_BOUND;
                    state_next    = ST_THRESH;
                end
            end
            ST_THRESH: begin
                if (!status.div_busy) begin
                    cmd.thr_load = 1'b1;
                    state_next   = ST_MIX_ADD;
                end
            end
            ST_MIX_ADD: begin
                cmd.gen_add = 1'b1;
                state_next  = ST_MULA;
            end
            ST_MULA: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_A;
                state_next    = ST_MULA_WAIT;
            end
            ST_MULA_WAIT: begin
                if (!status.mul_busy) begin
                    state_next = ST_XOR27;
                end
            end
            ST_XOR27: begin
                cmd.xor27  = 1'b1;
                state_next = ST_MULB;
            end
            ST_MULB: begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_B;
                state_next    = ST_MULB_WAIT;
            end
            ST_MULB_WAIT: begin
                if (!status.mul_busy) begin
                    state_next = ST_XOR31;
                end
            end
            ST_XOR31: begin
                cmd.xor31  = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST: begin
                // A draw below the threshold is thrown away and another is made.
                if (status.draw_ok) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_DRAW;
                    state_next    = ST_REM_WAIT;
                end else begin
                    state_next = ST_MIX_ADD;
                end
            end
            ST_REM_WAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

### rtl/splitmix64_bounded_random_core.sv
// Top level of the bounded SplitMix64 random core.
//
// Usage: each transfer on the s_ channel carries a 64-bit bound; the m_
// channel returns one value uniformly distributed in 0 .. bound-1, or 0
// when the bound is 0 or 1. Results come back in request order.
// The generator state resets to 1; a write on cfg_wr_en/cfg_wr_data loads
// the written seed into the generator state at that clock edge. Write the
// seed only while no request is in flight.
// Sequence: a bound of 0 or 1 returns without advancing the generator. Any
// other bound first computes the threshold remainder, then mixes each draw,
// then computes the final remainder, paced by the one-bit-per-cycle divider
// and the shared 32x32 multiplier. Each rejected draw adds another mix; at
// most half of draws are rejected.
// One request is worked on at a time; s_tready is high only when idle.
// The result waits in an output register while the receiver stalls, and
// the next request may be accepted and computed meanwhile; it then holds
// until the output register is free.
`timescale 1ns / 1ps

module splitmix64_bounded_random_core
    import smbr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,   // seed
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,       // [63:0] bound
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata        // [63:0] value
);

    dp_cmd_t    cmd;
    dp_status_t status;

    smbr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    smbr_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .bound_in    (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .value_out   (m_tdata)
    );

    // The multiplier and divider never run at the same time.
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(status.div_busy && status.mul_busy))
        else $error("divider and multiplier busy together");

    // Nothing is in progress when a new request may be accepted.
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!status.div_busy && !status.mul_busy))
        else $error("unit busy while accepting a request");

    // The result is loaded only after the final remainder has settled.
    a_out_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!status.div_busy && !cmd.div_start))
        else $error("output loaded while divider running");

    // A divide is started only while the divider is free.
    a_div_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !status.div_busy)
        else $error("divider restarted while busy");

    // A loaded result is presented with m_tvalid in the cycle after the load.
    a_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("loaded result not presented");

endmodule
